@@ rtl/coalesced_hash_index_builder_defines.svh @@
// assertion macros for the coalesced hash index builder
`ifndef COALESCED_HASH_INDEX_BUILDER_DEFINES_SVH
`define COALESCED_HASH_INDEX_BUILDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHIB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/chib_pkg.sv @@
// shared types and constants of the coalesced hash index builder
package chib_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int SLOT_W = 8;
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 4'd8;
  localparam logic [CFG_W-1:0] SIZE_LOG2_MIN = 4'd1;
  localparam logic [CFG_W-1:0] SIZE_LOG2_MAX = 4'd8;
  localparam logic [SLOT_W-1:0] FIRST_RECORD = 8'd1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_HOME,
    S_WALK,
    S_PROBE,
    S_WR_NEW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rec;
    logic [SLOT_W-1:0] link;
  } slot_entry_t;

endpackage

@@ rtl/chib_slot_ram.sv @@
// slot memory with per-entry valid bits, one write and one registered read port
module chib_slot_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  chib_pkg::slot_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output chib_pkg::slot_entry_t rd_data
);
  import chib_pkg::*;

  slot_entry_t       mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  slot_entry_t       rd_word_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

@@ rtl/coalesced_hash_index_builder.sv @@
// top level of the coalesced hash index builder
// Coalesced hash index builder.
// Input channel in_*: one transfer per operation, in_tuser selects clear,
// insert, read or no-op; in_tdata carries the key hash and the read slot.
// Output channel out_*: exactly one result transfer per input transfer, in
// order; out_tuser flags a refused insert on a full table.
// Config: cfg_wr_en/cfg_wr_data write size_log2 (window is 2^size_log2 slots);
// the user writes it only while the block is idle; this is not enforced.
// An insert stores its record in the home slot when that is free, else it
// walks the chain to its tail (up to the table depth in steps), probes the
// window for a free slot (up to the window size minus one probes) and links
// the tail to it. Every chain step and every probe is one registered read
// of the single slot memory, and linking an entry takes two writes.
// One operation is worked on at a time; the next one is taken while the
// previous result still sits in the output register.
// A stalled receiver holds the output register; the block then finishes its
// current operation and waits before delivering it.
// Reset (synchronous, rst_n low) empties the table through its valid bits at
// once, restarts record numbering at 1 and sets size_log2 to 8.
`include "coalesced_hash_index_builder_defines.svh"

module coalesced_hash_index_builder #(
  parameter int TABLE_DEPTH = chib_pkg::DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [chib_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [39:0]              in_tdata,   // key_hash, read_slot
  input  logic [1:0]               in_tuser,   // operation
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [23:0]              out_tdata,  // record_number, next_slot, placed_slot
  output logic [0:0]               out_tuser   // status
);
  import chib_pkg::*;

  localparam int MEM_DEPTH = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int STEP_W    = $clog2(TABLE_DEPTH + 1);
  localparam logic [16:0] TD_L = 17'(TABLE_DEPTH);
  localparam logic [STEP_W-1:0] TD_S = STEP_W'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  size_log2_r, size_log2_nxt;
  logic [SLOT_W-1:0] next_record_r, next_record_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] tail_rec_r, tail_rec_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [ADDR_W-1:0] tries_r, tries_nxt;
  logic              rd_in_range_r, rd_in_range_nxt;
  logic [SLOT_W-1:0] res_rec_r, res_rec_nxt;
  logic [SLOT_W-1:0] res_link_r, res_link_nxt;
  logic [SLOT_W-1:0] res_placed_r, res_placed_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;

  logic              mem_clear;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  slot_entry_t       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  slot_entry_t       rd_data;

  logic              in_fire;
  logic              out_free;
  op_t               in_op;
  logic [31:0]       in_hash;
  logic [SLOT_W-1:0] in_rs;
  logic              rs_in_range;
  logic [CFG_W-1:0]  lg_c;
  logic [8:0]        win_mask9;
  logic [ADDR_W-1:0] win_mask;
  logic [SLOT_W-1:0] nx;
  logic              walk_cont;
  logic              probe_empty;
  logic              probe_more;

  function automatic logic [ADDR_W-1:0] home_of(input logic [ADDR_W-1:0] v,
                                                input logic [ADDR_W-1:0] mask);
    logic [ADDR_W-1:0] h;
    h = v & mask;
    return (h == '0) ? ADDR_W'(1) : h;
  endfunction

  chib_slot_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mem_clear),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_op      = op_t'(in_tuser);
  assign in_hash    = in_tdata[31:0];
  assign in_rs      = in_tdata[39:32];
  assign rs_in_range = ({9'd0, in_rs} < TD_L);
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // window size log2 clamped to 1..8, then capped by the table depth through ADDR_W
  assign lg_c = (size_log2_r < SIZE_LOG2_MIN) ? SIZE_LOG2_MIN :
                (size_log2_r > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : size_log2_r;
  assign win_mask9 = 9'((9'd1 << lg_c) - 9'd1);
  assign win_mask  = win_mask9[ADDR_W-1:0];

  assign nx          = rd_data.link;
  assign walk_cont   = (steps_r < TD_S) && (nx != '0) && ({9'd0, nx} < TD_L);
  assign probe_empty = (rd_data.rec == '0);
  assign probe_more  = ({1'b0, tries_r} + 1'b1) < {1'b0, win_mask};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_INSERT: state_nxt = S_HOME;
            OP_READ:   state_nxt = S_READ;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_READ:   state_nxt = S_DONE;
      S_HOME: begin
        if (rd_data.rec == '0) begin
          state_nxt = S_DONE;
        end else if (walk_cont) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_WALK: begin
        if (!walk_cont) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_empty) begin
          state_nxt = S_WR_NEW;
        end else if (!probe_more) begin
          state_nxt = S_DONE;
        end
      end
      S_WR_NEW: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    size_log2_nxt   = cfg_wr_en ? cfg_wr_data : size_log2_r;
    next_record_nxt = next_record_r;
    slot_nxt        = slot_r;
    tail_nxt        = tail_r;
    tail_rec_nxt    = tail_rec_r;
    steps_nxt       = steps_r;
    tries_nxt       = tries_r;
    rd_in_range_nxt = rd_in_range_r;
    res_rec_nxt     = res_rec_r;
    res_link_nxt    = res_link_r;
    res_placed_nxt  = res_placed_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    mem_clear       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = slot_r;
    wr_data         = '{rec: next_record_r, link: '0};
    rd_en           = 1'b0;
    rd_addr         = slot_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_rec_nxt    = '0;
          res_link_nxt   = '0;
          res_placed_nxt = '0;
          res_status_nxt = 1'b0;
          unique case (in_op)
            OP_CLEAR: begin
              mem_clear       = 1'b1;
              next_record_nxt = FIRST_RECORD;
            end
            OP_INSERT: begin
              rd_en     = 1'b1;
              rd_addr   = home_of(in_hash[ADDR_W-1:0], win_mask);
              slot_nxt  = rd_addr;
              tail_nxt  = rd_addr;
              steps_nxt = '0;
            end
            OP_READ: begin
              rd_in_range_nxt = rs_in_range;
              rd_en           = rs_in_range;
              rd_addr         = in_rs[ADDR_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_rec_nxt  = rd_in_range_r ? rd_data.rec : '0;
        res_link_nxt = rd_in_range_r ? rd_data.link : '0;
      end
      S_HOME, S_WALK: begin
        if ((state_r == S_HOME) && (rd_data.rec == '0)) begin
          // home slot free: store the record right away
          wr_en           = 1'b1;
          wr_addr         = slot_r;
          res_rec_nxt     = next_record_r;
          res_placed_nxt  = SLOT_W'(slot_r);
          next_record_nxt = next_record_r + 1'b1;
        end else begin
          tail_rec_nxt = rd_data.rec;
          rd_en        = 1'b1;
          if (walk_cont) begin
            rd_addr   = nx[ADDR_W-1:0];
            tail_nxt  = nx[ADDR_W-1:0];
            steps_nxt = steps_r + 1'b1;
          end else begin
            // tail reached: probing restarts inside the window
            rd_addr   = home_of(tail_r + 1'b1, win_mask);
            slot_nxt  = rd_addr;
            tries_nxt = '0;
          end
        end
      end
      S_PROBE: begin
        if (probe_empty) begin
          wr_en   = 1'b1;
          wr_addr = tail_r;
          wr_data = '{rec: tail_rec_r, link: SLOT_W'(slot_r)};
        end else if (probe_more) begin
          rd_en     = 1'b1;
          rd_addr   = home_of(slot_r + 1'b1, win_mask);
          slot_nxt  = rd_addr;
          tries_nxt = tries_r + 1'b1;
        end else begin
          res_status_nxt = 1'b1;
        end
      end
      S_WR_NEW: begin
        wr_en           = 1'b1;
        wr_addr         = slot_r;
        res_rec_nxt     = next_record_r;
        res_placed_nxt  = SLOT_W'(slot_r);
        next_record_nxt = next_record_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {res_placed_r, res_link_r, res_rec_r};
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      size_log2_r   <= SIZE_LOG2_RST;
      next_record_r <= FIRST_RECORD;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      size_log2_r   <= size_log2_nxt;
      next_record_r <= next_record_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    tail_r        <= tail_nxt;
    tail_rec_r    <= tail_rec_nxt;
    steps_r       <= steps_nxt;
    tries_r       <= tries_nxt;
    rd_in_range_r <= rd_in_range_nxt;
    res_rec_r     <= res_rec_nxt;
    res_link_r    <= res_link_nxt;
    res_placed_r  <= res_placed_nxt;
    res_status_r  <= res_status_nxt;
    out_data_r    <= out_data_nxt;
    out_status_r  <= out_status_nxt;
  end

  `CHIB_ASSERT_SAME(a_no_slot_zero, wr_en, wr_addr != '0, "write to slot zero")
  `CHIB_ASSERT_SAME(a_full_empty, out_valid_r && out_status_r, out_data_r == '0,
                    "refused insert carries data")
  `CHIB_ASSERT_NEXT(a_insert_home, in_fire && (in_op == OP_INSERT), state_r == S_HOME,
                    "insert did not start at home slot")

endmodule
